@@ design/clt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, codes and character helpers for the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int CHAR_BITS = 8;

  // result kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NO_SPACE     = 3'd1;
  localparam logic [2:0] ERR_ESCAPE       = 3'd2;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd3;
  localparam logic [2:0] ERR_EMPTY        = 3'd4;

  // queue entry operations
  localparam logic [2:0] OP_CHAR       = 3'd0;
  localparam logic [2:0] OP_END        = 3'd1;
  localparam logic [2:0] OP_ACCEPT     = 3'd2;
  localparam logic [2:0] OP_END_ACCEPT = 3'd3;
  localparam logic [2:0] OP_REJECT     = 3'd4;

  localparam logic [CHAR_BITS-1:0] QUOTE_CH  = CHAR_BITS'(8'h22);
  localparam logic [CHAR_BITS-1:0] ESCAPE_CH = CHAR_BITS'(8'h5C);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0]           op;
    logic [CHAR_BITS-1:0] ch;
    logic [2:0]           err;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_wr_t;

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return c inside {CHAR_BITS'(8'h20), [CHAR_BITS'(8'h09):CHAR_BITS'(8'h0D)]};
  endfunction

  function automatic logic [CHAR_BITS-1:0] unescape(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] r;
    case (c)
      CHAR_BITS'(8'h6E): r = CHAR_BITS'(8'h0A);
      CHAR_BITS'(8'h72): r = CHAR_BITS'(8'h0D);
      CHAR_BITS'(8'h74): r = CHAR_BITS'(8'h09);
      CHAR_BITS'(8'h76): r = CHAR_BITS'(8'h0B);
      default:           r = c;
    endcase
    return r;
  endfunction

endpackage

@@ design/clt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front
// Per-character parse state; classifies each item into at most one queue entry.
// ----------------------------------------------------------------------------
module clt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [clt_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          line_end,
  output clt_pkg::queue_wr_t            wr
);
  import clt_pkg::*;

  logic       in_quote, in_quote_next;
  logic       in_escape, in_escape_next;
  logic       after_quote, after_quote_next;
  logic       word_nonempty, word_nonempty_next;
  logic       seen_nonspace, seen_nonspace_next;
  logic       held_valid, held_valid_next;
  logic [2:0] error_held, error_held_next;

  logic       ws;
  logic [2:0] err;

  assign ws = is_space(char_code);

  always_comb begin
    in_quote_next      = in_quote;
    in_escape_next     = in_escape;
    after_quote_next   = after_quote;
    word_nonempty_next = word_nonempty;
    seen_nonspace_next = seen_nonspace;
    held_valid_next    = held_valid;
    error_held_next    = error_held;
    wr.valid           = 1'b0;
    wr.entry.op        = OP_CHAR;
    wr.entry.ch        = '0;
    wr.entry.err       = ERR_NONE;
    err                = ERR_NONE;

    if (line_end) begin
      if (error_held != ERR_NONE) err = error_held;
      else if (!seen_nonspace) err = ERR_EMPTY;
      else if (in_escape || held_valid) err = ERR_ESCAPE;
      else if (in_quote) err = ERR_UNTERMINATED;
      wr.valid = 1'b1;
      if (err != ERR_NONE) begin
        wr.entry.op  = OP_REJECT;
        wr.entry.err = err;
      end else begin
        wr.entry.op = word_nonempty ? OP_END_ACCEPT : OP_ACCEPT;
      end
      in_quote_next      = 1'b0;
      in_escape_next     = 1'b0;
      after_quote_next   = 1'b0;
      word_nonempty_next = 1'b0;
      seen_nonspace_next = 1'b0;
      held_valid_next    = 1'b0;
      error_held_next    = ERR_NONE;
    end else if (error_held == ERR_NONE && (seen_nonspace || !ws)) begin
      seen_nonspace_next = 1'b1;
      if (!ws) held_valid_next = 1'b0;
      if (in_escape) begin
        wr.valid           = 1'b1;
        wr.entry.ch        = unescape(char_code);
        word_nonempty_next = 1'b1;
        in_escape_next     = 1'b0;
        // escaped whitespace may still turn out to be trailing
        if (ws) held_valid_next = 1'b1;
      end else if (after_quote && !ws) begin
        error_held_next = ERR_NO_SPACE;
      end else if (char_code == ESCAPE_CH) begin
        in_escape_next = 1'b1;
      end else if (in_quote) begin
        if (char_code == QUOTE_CH) begin
          in_quote_next    = 1'b0;
          after_quote_next = 1'b1;
        end else begin
          wr.valid           = 1'b1;
          wr.entry.ch        = char_code;
          word_nonempty_next = 1'b1;
        end
      end else begin
        after_quote_next = 1'b0;
        if (char_code == QUOTE_CH) begin
          in_quote_next = 1'b1;
        end else if (ws) begin
          if (word_nonempty) begin
            wr.valid    = 1'b1;
            wr.entry.op = OP_END;
          end
          word_nonempty_next = 1'b0;
        end else begin
          wr.valid           = 1'b1;
          wr.entry.ch        = char_code;
          word_nonempty_next = 1'b1;
        end
      end
    end

    if (!accept) wr.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote      <= 1'b0;
      in_escape     <= 1'b0;
      after_quote   <= 1'b0;
      word_nonempty <= 1'b0;
      seen_nonspace <= 1'b0;
      held_valid    <= 1'b0;
      error_held    <= ERR_NONE;
    end else if (accept) begin
      in_quote      <= in_quote_next;
      in_escape     <= in_escape_next;
      after_quote   <= after_quote_next;
      word_nonempty <= word_nonempty_next;
      seen_nonspace <= seen_nonspace_next;
      held_valid    <= held_valid_next;
      error_held    <= error_held_next;
    end
  end

endmodule

@@ design/clt_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_fifo
// Short entry queue between the parse front and the result back end.
// ----------------------------------------------------------------------------
module clt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  clt_pkg::queue_wr_t wr,
  input  logic               rd,
  output clt_pkg::entry_t    head,
  output logic               nonempty,
  output logic               full
);
  import clt_pkg::*;

  entry_t                    slots [QUEUE_DEPTH];
  logic [QUEUE_IDX_BITS-1:0] wptr;
  logic [QUEUE_IDX_BITS-1:0] rptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_rd;

  assign full     = count == QUEUE_CNT_BITS'(QUEUE_DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rptr];
  assign do_rd    = rd && nonempty;

  always_ff @(posedge clk) begin
    if (wr.valid) slots[wptr] <= wr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.valid) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (wr.valid && !do_rd) count <= count + 1'b1;
      else if (!wr.valid && do_rd) count <= count - 1'b1;
    end
  end

endmodule

@@ design/clt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_back
// Expands queue entries into result items and holds them in an output register.
// ----------------------------------------------------------------------------
module clt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  clt_pkg::entry_t               head,
  input  logic                          nonempty,
  output logic                          rd,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    kind,
  output logic [clt_pkg::CHAR_BITS-1:0] out_char,
  output logic [2:0]                    error_code,
  output logic                          last
);
  import clt_pkg::*;

  logic out_valid;
  logic pend;
  logic advance;

  assign empty   = !out_valid;
  assign advance = !out_valid || pop;
  assign rd      = advance && !pend && nonempty;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pend) begin
        kind       <= KIND_ACCEPT;
        out_char   <= '0;
        error_code <= ERR_NONE;
        last       <= 1'b1;
      end else begin
        out_char   <= head.ch;
        error_code <= head.err;
        last       <= head.op != OP_END_ACCEPT;
        case (head.op)
          OP_CHAR:       kind <= KIND_CHAR;
          OP_END:        kind <= KIND_END;
          OP_ACCEPT:     kind <= KIND_ACCEPT;
          OP_END_ACCEPT: kind <= KIND_END;
          OP_REJECT:     kind <= KIND_REJECT;
          default:       kind <= KIND_REJECT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (advance) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        out_valid <= nonempty;
        // word end first, accept follows in the next slot
        pend      <= nonempty && head.op == OP_END_ACCEPT;
      end
    end
  end

endmodule

@@ design/command_line_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a line, one character per item, into word characters and word ends.
// ----------------------------------------------------------------------------
// Input channel: push/full. Each item is one character, or an end-of-line
// marker (line_end high, char_code ignored). While full is low, one item is
// taken per cycle. Result channel: empty/pop. kind says word character, word
// end, line accepted or line rejected (with error_code); last marks the final
// result of an item. Items that cause no result (leading whitespace, quotes,
// a backslash) produce nothing on this side.
// An accepted item is written into the queue, then moved into the output
// register. Throughput: one item per cycle while full is low; an end
// marker that closes a word yields a word end and an accept, so a run of short
// words with end markers can queue results faster than one per cycle drains.
// A four-entry queue separates the parser from the output register; full
// rises when the queue fills, either because the receiver stalls or because
// such two-result end markers pile up; while empty is low and pop is low the
// result holds.
// Reset clears the parse state, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module command_line_tokenizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [clt_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          line_end,
  input  logic                          pop,
  output logic                          empty,
  output logic [1:0]                    kind,
  output logic [clt_pkg::CHAR_BITS-1:0] out_char,
  output logic [2:0]                    error_code,
  output logic                          last
);
  import clt_pkg::*;

  queue_wr_t wr;
  entry_t    head;
  logic      nonempty;
  logic      rd;
  logic      accept;

  assign accept = push && !full;

  clt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .line_end  (line_end),
    .wr        (wr)
  );

  clt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd       (rd),
    .head     (head),
    .nonempty (nonempty),
    .full     (full)
  );

  clt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .nonempty   (nonempty),
    .rd         (rd),
    .pop        (pop),
    .empty      (empty),
    .kind       (kind),
    .out_char   (out_char),
    .error_code (error_code),
    .last       (last)
  );

endmodule

@@ design/clt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module clt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          pop,
  input logic                          empty,
  input logic [1:0]                    kind,
  input logic [clt_pkg::CHAR_BITS-1:0] out_char,
  input logic [2:0]                    error_code,
  input logic                          last
);
  import clt_pkg::*;

  // nothing waits and nothing blocks right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full seen after reset");

  a_error_only_on_reject: assert property (@(posedge clk) disable iff (rst)
    !empty && kind != KIND_REJECT |-> error_code == ERR_NONE)
    else $error("error code on a non-reject result");

  a_reject_has_code: assert property (@(posedge clk) disable iff (rst)
    !empty && kind == KIND_REJECT |-> error_code != ERR_NONE)
    else $error("reject without error code");

  // line verdicts always close out their item
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    !empty && (kind == KIND_ACCEPT || kind == KIND_REJECT) |-> last)
    else $error("accept or reject not marked last");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(kind) && $stable(out_char)
      && $stable(error_code) && $stable(last))
    else $error("stalled result changed");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .kind       (kind),
  .out_char   (out_char),
  .error_code (error_code),
  .last       (last)
);
